@@ hw/rtl/ssks_pkg.sv @@
// Shared constants, types and the arctangent table of the stick sector key selector.
// Depends on nothing; the CORDIC, radius unit, edge divider, top level and verif files import it.
`default_nettype none

package ssks_pkg;

  // Angle and sector geometry
  localparam int ANGLE_BITS   = 16;
  localparam int MAX_SECTORS  = 16;
  localparam int BASE_SECTORS = 8;
  localparam int SECT_LIMIT   = (MAX_SECTORS < 16) ? MAX_SECTORS : 16;

  // Datapath widths
  localparam int PHASE_W      = 32;
  localparam int DELTA_W      = 17;
  localparam int CORDIC_STEPS = 24;
  localparam int PRE_SCALE    = 14;
  localparam int CORDIC_W     = 34;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ROOT_W       = 17;
  localparam int SQ_W         = 2 * ROOT_W;
  localparam int DIV_IDX_W    = 5;
  localparam int DIV_DEN_W    = 7;
  localparam int DIV_REM_W    = DIV_DEN_W + 1;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_ANGLE_OFS  = 3'd2,
    REG_SECT_COUNT = 3'd3,
    REG_KEY_COUNTS = 3'd4,
    REG_SECT_HYS   = 3'd5,
    REG_KEY_HYS    = 3'd6
  } ssks_reg_t;

  localparam logic [15:0] CENTER_RST      = 16'd32768;
  localparam logic [4:0]  SECT_COUNT_RST  = 5'd8;
  localparam logic [23:0] KEY_COUNTS_RST  = 24'h764924;

  // Request into and response out of the edge divider
  typedef struct packed {
    logic                 go;
    logic [DIV_IDX_W-1:0] idx;
    logic [DIV_DEN_W-1:0] den;
  } ssks_div_req_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] q;
  } ssks_div_rsp_t;

  // atan(2^-i) in 1/2^32 turns
  function automatic logic [PHASE_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [PHASE_W-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssks_if.sv @@
// Valid/ready channel interfaces for stick samples and selection results.
// Depends on nothing.
`default_nettype none

interface ssks_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic        restart;

  modport source (output valid, x_pos, y_pos, restart, input ready);
  modport sink   (input valid, x_pos, y_pos, restart, output ready);
endinterface

interface ssks_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle;
  logic [16:0] radius;
  logic [3:0]  sector;
  logic [2:0]  key_index;
  logic        key_valid;

  modport source (output valid, angle, radius, sector, key_index, key_valid, input ready);
  modport sink   (input valid, angle, radius, sector, key_index, key_valid, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ssks_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle, phase in 1/2^32 turns.
// Depends on ssks_pkg (widths, step count, arctangent table).
`default_nettype none

module ssks_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic signed [ssks_pkg::DELTA_W-1:0] dx,
  input  logic signed [ssks_pkg::DELTA_W-1:0] dy,
  output logic                            done,
  output logic [ssks_pkg::PHASE_W-1:0]    phase
);
  import ssks_pkg::*;

  localparam int DROP = PHASE_W - ANGLE_BITS;
  localparam logic [PHASE_W-1:0] HALF = PHASE_W'(1) << (DROP - 1);
  localparam logic [PHASE_W-1:0] MASK = ~((PHASE_W'(1) << DROP) - PHASE_W'(1));

  logic signed [CORDIC_W-1:0] x, y, xs, ys, dx_w, dy_w;
  logic [PHASE_W-1:0]         z;
  logic [STEP_W-1:0]          step;
  logic                       busy;

  assign dx_w = CORDIC_W'(dx);
  assign dy_w = CORDIC_W'(dy);
  assign xs   = x >>> step;
  assign ys   = y >>> step;

  // Sequence the rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (go) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Fold to the right half plane, then rotate toward the x axis
  always_ff @(posedge clk) begin
    if (go) begin
      if (dx < 0) begin
        x <= (-dx_w) <<< PRE_SCALE;
        y <= (-dy_w) <<< PRE_SCALE;
        z <= PHASE_W'(1) << (PHASE_W - 1);
      end else begin
        x <= dx_w <<< PRE_SCALE;
        y <= dy_w <<< PRE_SCALE;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_turn(step);
      end else if (y < 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_turn(step);
      end
    end
  end

  // Round to the angle resolution
  assign phase = (z + HALF) & MASK;

endmodule

`default_nettype wire

@@ hw/rtl/ssks_isqrt.sv @@
// Radius unit: squares both deltas on one multiplier, then a digit-by-digit square root.
// Depends on ssks_pkg (widths).
`default_nettype none

module ssks_isqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [ssks_pkg::DELTA_W-1:0] dx,
  input  logic signed [ssks_pkg::DELTA_W-1:0] dy,
  output logic                                done,
  output logic [ssks_pkg::ROOT_W-1:0]         root
);
  import ssks_pkg::*;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_SQ_X = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_SQ_Y = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_SUM  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 + ROOT_W);

  logic signed [DELTA_W-1:0] dxr, dyr, m_op;
  logic signed [2*DELTA_W-1:0] sq;
  logic [SQ_W-2:0] prod;
  logic [SQ_W-1:0] v, res, bitv;
  logic [SQ_W:0]   trial;
  logic [CNT_W-1:0] cnt;
  logic busy;

  assign m_op  = (cnt == CNT_SQ_X) ? dxr : dyr;
  assign sq    = m_op * m_op;
  assign trial = {1'b0, res} + {1'b0, bitv};

  // Sequence squaring, summing and root digits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dxr <= dx;
      dyr <= dy;
    end else if (busy) begin
      if (cnt == CNT_SQ_X) begin
        prod <= sq[SQ_W-2:0];
      end else if (cnt == CNT_SQ_Y) begin
        prod <= sq[SQ_W-2:0];
        v    <= {1'b0, prod};
      end else if (cnt == CNT_SUM) begin
        v    <= v + {1'b0, prod};
        res  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 2);
      end else begin
        // One root digit: subtract the trial value where it fits
        if ({1'b0, v} >= trial) begin
          v   <= v - trial[SQ_W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end

  // Saturate at the result width
  assign root = (|res[SQ_W-1:ROOT_W]) ? {ROOT_W{1'b1}} : res[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/ssks_edge_div.sv @@
// Edge divider: ceil(idx * 2^32 / den) modulo 2^32, eight quotient bits per cycle.
// Depends on ssks_pkg (request and response types, widths).
`default_nettype none

module ssks_edge_div (
  input  logic                    clk,
  input  logic                    rst,
  input  ssks_pkg::ssks_div_req_t req,
  output ssks_pkg::ssks_div_rsp_t rsp
);
  import ssks_pkg::*;

  localparam int CHUNK  = 8;
  localparam int ROUNDS = PHASE_W / CHUNK;
  localparam int RND_W  = $clog2(ROUNDS);

  logic [DIV_REM_W-1:0] r, rr;
  logic [DIV_REM_W:0]   t;
  logic [DIV_DEN_W-1:0] den;
  logic [CHUNK-1:0]     qb;
  logic [PHASE_W-1:0]   q;
  logic [RND_W-1:0]     rnd;
  logic                 busy, fin, done;
  logic [DIV_REM_W-1:0] idx_w, den_w;

  assign idx_w = DIV_REM_W'(req.idx);
  assign den_w = DIV_REM_W'(req.den);

  // Long-division chunk on the running remainder
  always_comb begin
    rr = r;
    qb = '0;
    t  = '0;
    for (int k = 0; k < CHUNK; k++) begin
      t = {rr, 1'b0};
      if (t >= (DIV_REM_W + 1)'(den)) begin
        rr            = DIV_REM_W'(t - (DIV_REM_W + 1)'(den));
        qb[CHUNK-1-k] = 1'b1;
      end else begin
        rr = t[DIV_REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else if (req.go) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else if (busy) begin
      rnd <= rnd + RND_W'(1);
      if (rnd == RND_W'(ROUNDS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end else if (fin) begin
      fin  <= 1'b0;
      done <= 1'b1;
    end
  end

  // Integer part is one only at the full turn, which wraps to zero
  always_ff @(posedge clk) begin
    if (req.go) begin
      den <= req.den;
      r   <= (idx_w >= den_w) ? idx_w - den_w : idx_w;
      q   <= '0;
    end else if (busy) begin
      r <= rr;
      q <= {q[PHASE_W-CHUNK-1:0], qb};
    end else if (fin) begin
      q <= q + PHASE_W'(r != '0);
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;

endmodule

`default_nettype wire

@@ hw/rtl/stick_sector_key_selector.sv @@
// Top level of the stick sector key selector: config registers, sequencer, hysteresis.
// Depends on ssks_pkg, ssks_if, ssks_cordic, ssks_isqrt and ssks_edge_div.
//
//   channel   dir  handshake          word
//   sample    in   valid/ready        x_pos, y_pos, restart
//   result    out  valid/ready        angle, radius, sector, key_index, key_valid
//   apb       in   psel/penable       7 registers at byte address 4*i, pready tied high
//
// From acceptance to a valid result a word goes through 24 CORDIC rotations,
// then edge divisions on the shared divider (sector edges, sector start, key edges).
// The next word is accepted the cycle after the result is loaded into the output
// register, even while that result still waits for ready.
// Reset (rst, synchronous) restores register defaults and clears the history.
`default_nettype none

module stick_sector_key_selector (
  input  logic                          clk,
  input  logic                          rst,
  ssks_in_if.sink                       sample,
  ssks_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssks_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssks_pkg::DATA_W-1:0]   pwdata,
  output logic [ssks_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ssks_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_START = 10'b0000000010,
    S_RUN   = 10'b0000000100,
    S_SRAW  = 10'b0000001000,
    S_SMUL  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_SDEC  = 10'b0001000000,
    S_SKEY  = 10'b0010000000,
    S_KMUL  = 10'b0100000000,
    S_KDEC  = 10'b1000000000
  } state_t;

  // Division jobs, in issue order
  localparam logic [2:0] JOB_SECT_LO = 3'd0;
  localparam logic [2:0] JOB_SECT_HI = 3'd1;
  localparam logic [2:0] JOB_START   = 3'd2;
  localparam logic [2:0] JOB_KEY_LO  = 3'd3;
  localparam logic [2:0] JOB_KEY_HI  = 3'd4;

  state_t state, state_next;

  // Configuration registers
  logic [15:0] center_x, center_y, angle_offset, sector_hys, key_hys;
  logic [4:0]  sector_count;
  logic [23:0] key_counts;
  logic        cfg_wr;
  ssks_reg_t   cfg_sel;

  // History
  logic [3:0] last_sector;
  logic [2:0] last_key;
  logic       history_valid;

  // Work registers
  logic signed [DELTA_W-1:0] dx, dy;
  logic                      fresh;
  logic [PHASE_W-1:0]        p, se0, se1, start_e, ke0, ke1;
  logic [3:0]                sector_raw, sector;
  logic [2:0]                kc, key_raw;
  logic [DIV_DEN_W-1:0]      sc;
  logic [2:0]                job, launch_job;

  // Output register
  logic        out_valid;
  logic [15:0] out_angle;
  logic [16:0] out_radius;
  logic [3:0]  out_sector;
  logic [2:0]  out_key;
  logic        out_key_valid;

  // Unit interfaces
  logic                cordic_go, cordic_done, sqrt_done;
  logic [PHASE_W-1:0]  phase;
  logic [ROOT_W-1:0]   root;
  ssks_div_req_t       div_req;
  ssks_div_rsp_t       div_rsp;

  // Combinational datapath
  logic [4:0]              s_eff;
  logic [PHASE_W+4:0]      ps;
  logic [4:0]              sraw_w;
  logic [PHASE_W-1:0]      local_p;
  logic [PHASE_W+6:0]      pk;
  logic [6:0]              kraw_w;
  logic                    keep_s, keep_k, out_free;
  logic [2:0]              key_final, slot_c;
  logic [$clog2(BASE_SECTORS)-1:0] slot;

  function automatic logic near_edges(input logic [PHASE_W-1:0] pa,
                                      input logic [PHASE_W-1:0] e0,
                                      input logic [PHASE_W-1:0] e1,
                                      input logic [15:0] margin);
    logic [PHASE_W-1:0] d0, d1, m;
    d0 = pa - e0;
    d1 = pa - e1;
    if (d0 > 32'h8000_0000) d0 = -d0;
    if (d1 > 32'h8000_0000) d1 = -d1;
    m = {margin, 16'h0000};
    return (d0 < m) || (d1 < m);
  endfunction

  // Configuration write and read
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = ssks_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CENTER_RST;
      center_y     <= CENTER_RST;
      angle_offset <= '0;
      sector_count <= SECT_COUNT_RST;
      key_counts   <= KEY_COUNTS_RST;
      sector_hys   <= '0;
      key_hys      <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_CENTER_X:   center_x     <= pwdata[15:0];
        REG_CENTER_Y:   center_y     <= pwdata[15:0];
        REG_ANGLE_OFS:  angle_offset <= pwdata[15:0];
        REG_SECT_COUNT: sector_count <= pwdata[4:0];
        REG_KEY_COUNTS: key_counts   <= pwdata[23:0];
        REG_SECT_HYS:   sector_hys   <= pwdata[15:0];
        REG_KEY_HYS:    key_hys      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_CENTER_X:   prdata = DATA_W'(center_x);
      REG_CENTER_Y:   prdata = DATA_W'(center_y);
      REG_ANGLE_OFS:  prdata = DATA_W'(angle_offset);
      REG_SECT_COUNT: prdata = DATA_W'(sector_count);
      REG_KEY_COUNTS: prdata = DATA_W'(key_counts);
      REG_SECT_HYS:   prdata = DATA_W'(sector_hys);
      REG_KEY_HYS:    prdata = DATA_W'(key_hys);
      default:        prdata = '0;
    endcase
  end

  // Clamp the sector count into range
  always_comb begin
    if (sector_count == 5'd0) begin
      s_eff = 5'd1;
    end else if (sector_count > 5'(SECT_LIMIT)) begin
      s_eff = 5'(SECT_LIMIT);
    end else begin
      s_eff = sector_count;
    end
  end

  // Raw sector and raw key quantizers
  assign ps      = (PHASE_W + 5)'(p) * (PHASE_W + 5)'(s_eff);
  assign sraw_w  = ps[PHASE_W+4:PHASE_W];
  assign local_p = p - start_e;
  assign pk      = (PHASE_W + 7)'(local_p) * (PHASE_W + 7)'(sc);
  assign kraw_w  = pk[PHASE_W+6:PHASE_W];
  assign slot    = ($clog2(BASE_SECTORS))'(sector % BASE_SECTORS);
  assign slot_c  = key_counts[3*slot +: 3];

  // Hysteresis decisions
  assign keep_s = !fresh && (5'(last_sector) < s_eff) && (sector_raw != last_sector) &&
                  near_edges(p, se0, se1, sector_hys);
  assign keep_k = !fresh && (last_key < kc) && (key_raw != last_key) &&
                  near_edges(p, ke0, ke1, key_hys);
  assign key_final = (kc == 3'd0) ? 3'd0 : (keep_k ? last_key : key_raw);
  assign out_free  = !out_valid || result.ready;

  // Shared units
  assign cordic_go = (state == S_START);

  ssks_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (cordic_go),
    .dx    (dx),
    .dy    (dy),
    .done  (cordic_done),
    .phase (phase)
  );

  ssks_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (cordic_go),
    .dx   (dx),
    .dy   (dy),
    .done (sqrt_done),
    .root (root)
  );

  // Launch the next division job
  always_comb begin
    div_req.go = 1'b0;
    launch_job = job;
    unique case (state)
      S_SMUL: begin
        div_req.go = 1'b1;
        launch_job = JOB_SECT_LO;
      end
      S_SKEY: begin
        div_req.go = 1'b1;
        launch_job = JOB_START;
      end
      S_DIV: begin
        if (div_rsp.done && (job == JOB_SECT_LO || job == JOB_START || job == JOB_KEY_LO)) begin
          div_req.go = 1'b1;
          launch_job = job + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.idx = DIV_IDX_W'(last_sector);
    div_req.den = DIV_DEN_W'(s_eff);
    case (launch_job)
      JOB_SECT_LO: div_req.idx = DIV_IDX_W'(last_sector);
      JOB_SECT_HI: div_req.idx = DIV_IDX_W'(last_sector) + DIV_IDX_W'(1);
      JOB_START:   div_req.idx = DIV_IDX_W'(sector);
      JOB_KEY_LO: begin
        div_req.idx = DIV_IDX_W'(last_key);
        div_req.den = sc;
      end
      JOB_KEY_HI: begin
        div_req.idx = DIV_IDX_W'(last_key) + DIV_IDX_W'(1);
        div_req.den = sc;
      end
      default: ;
    endcase
  end

  ssks_edge_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sample.valid) state_next = S_START;
      S_START: state_next = S_RUN;
      S_RUN:   if (cordic_done && sqrt_done) state_next = S_SRAW;
      S_SRAW:  state_next = S_SMUL;
      S_SMUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done && job == JOB_SECT_HI) begin
          state_next = S_SDEC;
        end else if (div_rsp.done && job == JOB_KEY_HI) begin
          state_next = S_KMUL;
        end
      end
      S_SDEC:  state_next = S_SKEY;
      S_SKEY:  state_next = S_DIV;
      S_KMUL:  state_next = S_KDEC;
      S_KDEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign sample.ready = (state == S_IDLE);

  // Control state: sequencer, history, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      job           <= JOB_SECT_LO;
      last_sector   <= '0;
      last_key      <= '0;
      history_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (div_req.go) job <= launch_job;
      // Load a finished word, else drop the one the sink took
      if (state == S_KDEC && out_free) begin
        out_valid     <= 1'b1;
        last_sector   <= sector;
        last_key      <= key_final;
        history_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      dx    <= $signed({1'b0, sample.x_pos}) - $signed({1'b0, center_x});
      dy    <= $signed({1'b0, sample.y_pos}) - $signed({1'b0, center_y});
      fresh <= sample.restart || !history_valid;
    end
    if (state == S_SRAW) p <= phase + {angle_offset, 16'h0000};
    if (state == S_SMUL) sector_raw <= (sraw_w >= s_eff) ? 4'(s_eff - 5'd1) : sraw_w[3:0];
    if (state == S_SDEC) sector <= keep_s ? last_sector : sector_raw;
    if (state == S_SKEY) begin
      kc <= slot_c;
      sc <= DIV_DEN_W'(s_eff) * DIV_DEN_W'(slot_c);
    end
    if (state == S_DIV && div_rsp.done) begin
      case (job)
        JOB_SECT_LO: se0     <= div_rsp.q;
        JOB_SECT_HI: se1     <= div_rsp.q;
        JOB_START:   start_e <= div_rsp.q;
        JOB_KEY_LO:  ke0     <= start_e + div_rsp.q;
        JOB_KEY_HI:  ke1     <= start_e + div_rsp.q;
        default: ;
      endcase
    end
    if (state == S_KMUL) key_raw <= (kraw_w >= 7'(kc)) ? kc - 3'd1 : kraw_w[2:0];
    if (state == S_KDEC && out_free) begin
      out_angle     <= p[PHASE_W-1:PHASE_W-16];
      out_radius    <= root;
      out_sector    <= sector;
      out_key       <= key_final;
      out_key_valid <= (kc != 3'd0);
    end
  end

  assign result.valid     = out_valid;
  assign result.angle     = out_angle;
  assign result.radius    = out_radius;
  assign result.sector    = out_sector;
  assign result.key_index = out_key;
  assign result.key_valid = out_key_valid;

endmodule

`default_nettype wire

@@ hw/rtl/ssks_checker.sv @@
// Port-level checks for the stick sector key selector, bound to its top level.
// Depends on stick_sector_key_selector and its channel interfaces.
`default_nettype none

module ssks_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] angle,
  input logic [16:0] radius,
  input logic [3:0]  sector,
  input logic [2:0]  key_index,
  input logic        key_valid
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // One word in flight: accepting drops ready
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while busy");

  // No result appears in the cycle right after acceptance
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result too early");

  // Sector without keys reports key slot zero
  a_empty_sector: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_valid) |-> (key_index == 3'd0))
    else $error("key index set for empty sector");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(angle) && $stable(radius) && $stable(sector) &&
       $stable(key_index) && $stable(key_valid)))
    else $error("stalled result changed");

endmodule

bind stick_sector_key_selector ssks_checker u_ssks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .angle     (result.angle),
  .radius    (result.radius),
  .sector    (result.sector),
  .key_index (result.key_index),
  .key_valid (result.key_valid)
);

`default_nettype wire

@@ verif/ssks_selector_checker.sv @@
// Checker of the stick sector key selector: mirrors the registers from APB writes,
// predicts each result word from accepted samples and compares it with the output.
// Depends on ssks_pkg and the channel interfaces in ssks_if.
`default_nettype none

module ssks_selector_checker (
  input  logic        clk,
  input  logic        rst,
  ssks_in_if          sample,
  ssks_out_if         result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssks_pkg::*;

  typedef struct packed {
    logic [15:0] angle;
    logic [16:0] radius;
    logic [3:0]  sector;
    logic [2:0]  key_index;
    logic        key_valid;
  } sel_word_t;

  // arctangent steps in 1/2^32 turns
  localparam logic [31:0] ATAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic [15:0] cen_x, cen_y, rot_ofs, sect_hys, key_hys;
  logic [4:0]  sect_cnt;
  logic [23:0] key_tbl;
  logic [3:0]  prev_sector;
  logic [2:0]  prev_key;
  logic        have_history;
  sel_word_t   selections_due[$];

  // CORDIC direction of (dx, dy) rounded to the angle resolution
  function automatic logic [31:0] stick_phase(input longint dx, input longint dy);
    longint cx, cy, xs, ys;
    logic [31:0] z;
    cx = dx;
    cy = dy;
    z = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z = 32'h80000000;
    end
    cx = cx * 16384;
    cy = cy * 16384;
    for (int i = 0; i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + ATAN_STEP[i];
      end else if (cy < 0) begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - ATAN_STEP[i];
      end
    end
    return (z + 32'h00008000) & 32'hFFFF0000;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // ceil(idx * 2^32 / den), wrapped to 32 bits
  function automatic logic [31:0] slot_edge(input longint unsigned idx,
                                            input longint unsigned den);
    longint unsigned q;
    q = ((idx << 32) + den - 1) / den;
    return q[31:0];
  endfunction

  function automatic logic [31:0] arc_gap(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    if (d > 32'h80000000) d = -d;
    return d;
  endfunction

  function automatic logic near_slot_edge(input logic [31:0] p, input logic [31:0] e0,
                                          input logic [31:0] e1, input logic [15:0] margin);
    longint unsigned m;
    m = longint'(margin) << 16;
    return (longint'(arc_gap(p, e0)) < m) || (longint'(arc_gap(p, e1)) < m);
  endfunction

  function automatic sel_word_t select_key(input logic [15:0] xp, input logic [15:0] yp,
                                           input logic rs);
    sel_word_t w;
    longint dx, dy;
    longint unsigned s, c, sc, rad;
    logic [31:0] p, start, local_ph;
    logic [3:0] sec;
    logic [2:0] key;
    logic fresh;
    longint unsigned t;
    dx = longint'(xp) - longint'(cen_x);
    dy = longint'(yp) - longint'(cen_y);
    fresh = rs || !have_history;
    s = 64'(sect_cnt);
    if (s < 1) s = 1;
    if (s > 16) s = 16;
    p = stick_phase(dx, dy) + {rot_ofs, 16'h0000};
    rad = root_floor(longint'(dx * dx) + longint'(dy * dy));
    if (rad > 131071) rad = 131071;
    t = (longint'(p) * s) >> 32;
    if (t >= s) t = s - 1;
    sec = t[3:0];
    if (!fresh && prev_sector < s && sec != prev_sector &&
        near_slot_edge(p, slot_edge(64'(prev_sector), s),
                       slot_edge(64'(prev_sector) + 64'd1, s), sect_hys))
      sec = prev_sector;
    c = 64'((key_tbl >> (3 * (sec % 8))) & 24'd7);
    key = '0;
    w.key_valid = 1'b0;
    if (c != 0) begin
      sc = s * c;
      w.key_valid = 1'b1;
      start = slot_edge(64'(sec), s);
      local_ph = p - start;
      t = (longint'(local_ph) * sc) >> 32;
      if (t >= c) t = c - 1;
      key = t[2:0];
      if (!fresh && prev_key < c && key != prev_key &&
          near_slot_edge(p, start + slot_edge(64'(prev_key), sc),
                         start + slot_edge(64'(prev_key) + 64'd1, sc), key_hys))
        key = prev_key;
    end
    prev_sector = sec;
    prev_key = key;
    have_history = 1'b1;
    w.angle = p[31:16];
    w.radius = rad[16:0];
    w.sector = sec;
    w.key_index = key;
    return w;
  endfunction

  assign pending = selections_due.size();

  // mirror registers, predict on every accepted sample
  always @(posedge clk) begin
    if (rst) begin
      cen_x <= CENTER_RST;
      cen_y <= CENTER_RST;
      rot_ofs <= '0;
      sect_cnt <= SECT_COUNT_RST;
      key_tbl <= KEY_COUNTS_RST;
      sect_hys <= '0;
      key_hys <= '0;
      prev_sector = '0;
      prev_key = '0;
      have_history = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ssks_reg_t'(paddr[4:2]))
          REG_CENTER_X:   cen_x <= pwdata[15:0];
          REG_CENTER_Y:   cen_y <= pwdata[15:0];
          REG_ANGLE_OFS:  rot_ofs <= pwdata[15:0];
          REG_SECT_COUNT: sect_cnt <= pwdata[4:0];
          REG_KEY_COUNTS: key_tbl <= pwdata[23:0];
          REG_SECT_HYS:   sect_hys <= pwdata[15:0];
          REG_KEY_HYS:    key_hys <= pwdata[15:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        selections_due.insert(selections_due.size(),
                              select_key(sample.x_pos, sample.y_pos, sample.restart));
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    sel_word_t exp_w, got_w;
    if (!rst && result.valid && result.ready) begin
      got_w = '{result.angle, result.radius, result.sector, result.key_index,
                result.key_valid};
      if (selections_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got_w);
      end else begin
        exp_w = selections_due.pop_front();
        checked++;
        if (exp_w != got_w) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp_w, got_w);
        end
      end
    end
  end
endmodule

`default_nettype wire

@@ verif/tb_stick_sector_key_selector.sv @@
// Top of the stick sector key selector testbench: clock, reset, APB setup,
// sample stimulus and result back-pressure; the verdict comes from the checker.
// Depends on ssks_pkg, ssks_if, the block and ssks_selector_checker.
`default_nettype none

module tb_stick_sector_key_selector;
  timeunit 1ns;
  timeprecision 1ps;
  import ssks_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          errors, pending, checked;
  int          send_idle, recv_idle, settings_run;
  int          walk_x, walk_y;
  logic [15:0] cfg_cx, cfg_cy;

  ssks_in_if  sample ();
  ssks_out_if result ();

  stick_sector_key_selector DUT (
    .clk, .rst, .sample(sample.sink), .result(result.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ssks_selector_checker checker_i (
    .clk, .rst, .sample, .result, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // throttle the result side
  always @(posedge clk) result.ready <= ($urandom_range(99) >= recv_idle);

  task automatic reg_write(input ssks_reg_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic drain();
    sample.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // hold a sample word until the block takes it
  task automatic send_word(input logic [15:0] xp, input logic [15:0] yp, input logic rs);
    while ($urandom_range(99) < send_idle) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.x_pos <= xp;
    sample.y_pos <= yp;
    sample.restart <= rs;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic set_all(input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] ofs,
                         input logic [4:0] sc, input logic [23:0] kc,
                         input logic [15:0] sh, input logic [15:0] kh);
    drain();
    repeat (70) @(posedge clk);
    reg_write(REG_CENTER_X, 32'(cx));
    reg_write(REG_CENTER_Y, 32'(cy));
    reg_write(REG_ANGLE_OFS, 32'(ofs));
    reg_write(REG_SECT_COUNT, 32'(sc));
    reg_write(REG_KEY_COUNTS, 32'(kc));
    reg_write(REG_SECT_HYS, 32'(sh));
    reg_write(REG_KEY_HYS, 32'(kh));
    cfg_cx = cx;
    cfg_cy = cy;
    walk_x = int'(cx);
    walk_y = int'(cy);
    settings_run++;
  endtask

  // mostly a wandering stick near the centre, some jumps and raw noise
  task automatic random_word();
    int pick, r;
    pick = $urandom_range(99);
    if (pick < 70) begin
      r = (pick < 20) ? 2000 : 300;
      walk_x += int'($urandom_range(2 * r)) - r;
      walk_y += int'($urandom_range(2 * r)) - r;
    end else if (pick < 80) begin
      walk_x = int'(cfg_cx) + int'($urandom_range(40000)) - 20000;
      walk_y = int'(cfg_cy) + int'($urandom_range(40000)) - 20000;
    end else if (pick < 85) begin
      walk_x = int'(cfg_cx) + int'($urandom_range(4)) - 2;
      walk_y = int'(cfg_cy) + int'($urandom_range(4)) - 2;
    end else begin
      walk_x = int'($urandom_range(65535));
      walk_y = int'($urandom_range(65535));
    end
    if (walk_x < 0) walk_x = 0;
    if (walk_x > 65535) walk_x = 65535;
    if (walk_y < 0) walk_y = 0;
    if (walk_y > 65535) walk_y = 65535;
    send_word(walk_x[15:0], walk_y[15:0], $urandom_range(99) < 8);
  endtask

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sample.valid <= 1'b0;
    sample.x_pos <= '0;
    sample.y_pos <= '0;
    sample.restart <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle = 0;
    recv_idle = 0;
    settings_run = 0;
    cfg_cx = CENTER_RST;
    cfg_cy = CENTER_RST;
    walk_x = int'(CENTER_RST);
    walk_y = int'(CENTER_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners, centre, axes, restart, under reset defaults
    send_word(16'd32768, 16'd32768, 1'b0);
    send_word(16'd0, 16'd0, 1'b0);
    send_word(16'd65535, 16'd65535, 1'b0);
    send_word(16'd0, 16'd65535, 1'b1);
    send_word(16'd65535, 16'd0, 1'b0);
    send_word(16'd65535, 16'd32768, 1'b0);
    send_word(16'd0, 16'd32768, 1'b0);
    send_word(16'd32768, 16'd65535, 1'b0);
    send_word(16'd32768, 16'd0, 1'b1);
    // zero sectors clamp to one, zero keys, full margins keep the previous slot
    set_all(16'd0, 16'd65535, 16'hFFFF, 5'd0, 24'h000000, 16'd32768, 16'hFFFF);
    send_word(16'd65535, 16'd0, 1'b0);
    send_word(16'd0, 16'd0, 1'b0);
    send_word(16'd40000, 16'd0, 1'b1);
    // oversize count clamps to 16, sectors past eight reuse the table
    set_all(16'd32768, 16'd32768, 16'd0, 5'd31, 24'hFFFFFF, 16'd2000, 16'd2000);
    send_word(16'd60000, 16'd32768, 1'b1);
    send_word(16'd60000, 16'd33000, 1'b0);
    send_word(16'd32768, 16'd60000, 1'b0);
    send_word(16'd5000, 16'd32000, 1'b0);
    send_word(16'd32768, 16'd32768, 1'b0);
    set_all(16'd32768, 16'd32768, 16'd0, 5'd16, 24'h0C5A38, 16'd0, 16'd32767);
    send_word(16'd40000, 16'd20000, 1'b0);
    send_word(16'd20000, 16'd40000, 1'b0);
    send_word(16'd21000, 16'd39000, 1'b0);

    // random phases, each with its own register setting and one of three idle patterns
    for (int k = 0; k < 6; k++) begin
      case (k % 3)
        0: begin send_idle = 28; recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (k == 0)
        set_all(16'd0, 16'd0, 16'd0, 5'd1, 24'hFFFFFF, 16'd0, 16'd0);
      else if (k == 1)
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd16, 24'h000FFF, 16'd32768, 16'd100);
      else
        set_all(16'($urandom_range(20000, 45000)), 16'($urandom_range(20000, 45000)),
                16'($urandom_range(65535)), 5'($urandom_range(31)),
                24'($urandom_range(24'hFFFFFF)),
                16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000)),
                16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000)));
      for (int n = 0; n < 250; n++) begin
        if (n == 120) drain();
        random_word();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("checked %0d result words over %0d register settings", checked, settings_run);
    $display("covered corners, centre, clamped counts, zero keys and wide margins");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/ssks_pkg.sv
hw/rtl/ssks_if.sv
hw/rtl/ssks_cordic.sv
hw/rtl/ssks_isqrt.sv
hw/rtl/ssks_edge_div.sv
hw/rtl/stick_sector_key_selector.sv
hw/rtl/ssks_checker.sv
verif/ssks_selector_checker.sv
verif/tb_stick_sector_key_selector.sv
